/* sv/assert_macros.svh */
// Assertion macros shared by the steering core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define DPS_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("steering core assertion failed");

// Clocked check that also runs through reset.
`define DPS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("steering core assertion failed");

`endif

/* sv/dps_pkg.sv */
// Shared types and constants for the differential PD steering core.
package dps_pkg;

    localparam int GAIN_W  = 12;
    localparam int SPEED_W = 16;
    localparam int THR_W   = 12;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 12'd700;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 12'd250;
    localparam logic [SPEED_W-1:0] BASE_RST      = 16'd25000;
    localparam logic [SPEED_W-1:0] MAX_RST       = 16'd37000;
    localparam logic [SPEED_W-1:0] MIN_RST       = 16'd13000;
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 12'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_D         = 3'd1,
        CFG_CRUISE         = 3'd2,
        CFG_DRIVE_CAP      = 3'd3,
        CFG_DRIVE_FLOOR    = 3'd4,
        CFG_LOST_THRESHOLD = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_d;
        logic [SPEED_W-1:0] cruise;
        logic [SPEED_W-1:0] drive_cap;
        logic [SPEED_W-1:0] drive_floor;
        logic [THR_W-1:0]   lost_threshold;
    } t_cfg;

endpackage

/* sv/differential_pd_steering_core.sv */
// Top level of the differential PD line-following steering core.
// Each item is one left/right reflectance sample pair; each item yields one
// result: a left and a right motor drive compare value and a line-lost flag.
// The steering error is left minus right; when both samples sit below the
// lost-line threshold the error holds at its previous value, so the
// derivative term drops to zero. The correction is
// gain_p*error + gain_d*(error - previous error); the left drive is the
// cruise value minus the correction and the right drive the cruise value
// plus it, each capped at the drive cap and then floored at the drive floor
// (the floor wins if the limits cross). The core is a three-stage pipeline:
// error and derivative, then the two gain products, then the correction sum
// and the clamp into the result register. It takes one item every cycle
// while ready is high; an accepted item passes through the error, product
// and drive registers in that order, the drive register being the result
// register. The product stage sets the cycle time. Ready drops only when
// all three stages hold items and the result is not taken. Configuration
// registers are written through a plain write port (index 0..5: gain_p,
// gain_d, cruise value, drive cap, drive floor, lost_threshold; other
// indexes are ignored) and must only change while no item is in flight.
// Samples are SAMPLE_BITS wide (8 to 16).
`include "assert_macros.svh"

module differential_pd_steering_core import dps_pkg::*; #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    // sample items
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_left_sample,
    input  logic [SAMPLE_BITS-1:0] i_right_sample,
    // drive results
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SPEED_W-1:0]     o_left_drive,
    output logic [SPEED_W-1:0]     o_right_drive,
    output logic                   o_line_lost
);

    localparam int ERR_W = SAMPLE_BITS + 1;
    localparam int DER_W = SAMPLE_BITS + 2;
    localparam int PP_W  = SAMPLE_BITS + GAIN_W + 2;
    localparam int PD_W  = SAMPLE_BITS + GAIN_W + 3;

    t_cfg r_cfg;

    // stage one to stage two
    logic                    s1_valid;
    logic                    s2_ready;
    logic signed [ERR_W-1:0] s1_err;
    logic signed [DER_W-1:0] s1_deriv;
    logic                    s1_lost;

    // stage two to stage three
    logic                    s2_valid;
    logic                    s3_ready;
    logic signed [PP_W-1:0]  s2_prod_p;
    logic signed [PD_W-1:0]  s2_prod_d;
    logic                    s2_lost;

    logic                    in_accept;

    // Configuration registers: write at the addressed index, drop the rest.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= GAIN_P_RST;
            r_cfg.gain_d         <= GAIN_D_RST;
            r_cfg.cruise         <= BASE_RST;
            r_cfg.drive_cap      <= MAX_RST;
            r_cfg.drive_floor    <= MIN_RST;
            r_cfg.lost_threshold <= THRESHOLD_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_P:         r_cfg.gain_p         <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:         r_cfg.gain_d         <= i_cfg_wdata[GAIN_W-1:0];
                CFG_CRUISE:         r_cfg.cruise         <= i_cfg_wdata[SPEED_W-1:0];
                CFG_DRIVE_CAP:      r_cfg.drive_cap      <= i_cfg_wdata[SPEED_W-1:0];
                CFG_DRIVE_FLOOR:    r_cfg.drive_floor    <= i_cfg_wdata[SPEED_W-1:0];
                CFG_LOST_THRESHOLD: r_cfg.lost_threshold <= i_cfg_wdata[THR_W-1:0];
                default: begin
                    // unmapped index: ignore the write
                end
            endcase
        end
    end

    // Error stage also owns the stored error, updated as each item enters.
    dps_error #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_error (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .i_lost_threshold (r_cfg.lost_threshold),
        .o_valid          (s1_valid),
        .i_ready          (s2_ready),
        .o_err            (s1_err),
        .o_deriv          (s1_deriv),
        .o_lost           (s1_lost)
    );

    dps_mult #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .o_ready  (s2_ready),
        .i_err    (s1_err),
        .i_deriv  (s1_deriv),
        .i_lost   (s1_lost),
        .i_gain_p (r_cfg.gain_p),
        .i_gain_d (r_cfg.gain_d),
        .o_valid  (s2_valid),
        .i_ready  (s3_ready),
        .o_prod_p (s2_prod_p),
        .o_prod_d (s2_prod_d),
        .o_lost   (s2_lost)
    );

    // Drive stage doubles as the result register.
    dps_drive #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_drive (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s2_valid),
        .o_ready       (s3_ready),
        .i_prod_p      (s2_prod_p),
        .i_prod_d      (s2_prod_d),
        .i_lost        (s2_lost),
        .i_cruise      (r_cfg.cruise),
        .i_drive_cap   (r_cfg.drive_cap),
        .i_drive_floor (r_cfg.drive_floor),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_left_drive  (o_left_drive),
        .o_right_drive (o_right_drive),
        .o_line_lost   (o_line_lost)
    );

    assign in_accept = i_valid && o_ready;

    // A lost line holds the error, so the derivative must be zero.
    `DPS_ASSERT_CLK(a_lost_zero_deriv, i_clk, i_rst_n, (s1_valid && s1_lost) |-> (s1_deriv == '0))
    // An accepted item always lands in the error stage.
    `DPS_ASSERT_CLK(a_accept_fills_s1, i_clk, i_rst_n, in_accept |=> s1_valid)
    // A product stage stalled by the drive stage keeps its item.
    `DPS_ASSERT_CLK(a_s2_hold, i_clk, i_rst_n, (s2_valid && !s3_ready) |=> (s2_valid && $stable(s2_prod_p) && $stable(s2_prod_d)))
    // Reset empties the result register.
    `DPS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

/* sv/dps_error.sv */
// Stage one: lost-line detect, steering error, derivative and stored error.
module dps_error import dps_pkg::*; #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [SAMPLE_BITS-1:0]        i_left_sample,
    input  logic [SAMPLE_BITS-1:0]        i_right_sample,
    input  logic [THR_W-1:0]              i_lost_threshold,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS:0]   o_err,
    output logic signed [SAMPLE_BITS+1:0] o_deriv,
    output logic                          o_lost
);

    localparam int ERR_W = SAMPLE_BITS + 1;
    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    logic                    r_valid;
    logic signed [ERR_W-1:0] r_last_error;
    logic signed [ERR_W-1:0] n_last_error;
    logic signed [ERR_W-1:0] r_err;
    logic signed [ERR_W:0]   n_deriv;
    logic signed [ERR_W:0]   r_deriv;
    logic                    n_lost;
    logic                    r_lost;
    logic signed [ERR_W-1:0] diff;
    logic                    load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_lost = (CMP_W'(i_left_sample) < CMP_W'(i_lost_threshold)) &&
                 (CMP_W'(i_right_sample) < CMP_W'(i_lost_threshold));
        diff   = $signed({1'b0, i_left_sample}) - $signed({1'b0, i_right_sample});
        // hold the previous error while the line is lost
        n_last_error = n_lost ? r_last_error : diff;
        n_deriv = $signed({n_last_error[ERR_W-1], n_last_error})
                - $signed({r_last_error[ERR_W-1], r_last_error});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_last_error <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_last_error <= n_last_error;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_err   <= n_last_error;
            r_deriv <= n_deriv;
            r_lost  <= n_lost;
        end
    end

    assign o_valid = r_valid;
    assign o_err   = r_err;
    assign o_deriv = r_deriv;
    assign o_lost  = r_lost;

endmodule

/* sv/dps_mult.sv */
// Stage two: proportional and derivative products.
module dps_mult import dps_pkg::*; #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [SAMPLE_BITS:0]          i_err,
    input  logic signed [SAMPLE_BITS+1:0]        i_deriv,
    input  logic                                 i_lost,
    input  logic [GAIN_W-1:0]                    i_gain_p,
    input  logic [GAIN_W-1:0]                    i_gain_d,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [SAMPLE_BITS+GAIN_W+1:0] o_prod_p,
    output logic signed [SAMPLE_BITS+GAIN_W+2:0] o_prod_d,
    output logic                                 o_lost
);

    localparam int ERR_W = SAMPLE_BITS + 1;
    localparam int DER_W = SAMPLE_BITS + 2;
    localparam int PP_W  = ERR_W + GAIN_W + 1;
    localparam int PD_W  = DER_W + GAIN_W + 1;

    logic                   r_valid;
    logic signed [PP_W-1:0] n_prod_p;
    logic signed [PP_W-1:0] r_prod_p;
    logic signed [PD_W-1:0] n_prod_d;
    logic signed [PD_W-1:0] r_prod_d;
    logic                   r_lost;
    logic                   load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_prod_p = $signed({{(GAIN_W+1){i_err[ERR_W-1]}}, i_err})
                 * $signed({{(ERR_W+1){1'b0}}, i_gain_p});
        n_prod_d = $signed({{(GAIN_W+1){i_deriv[DER_W-1]}}, i_deriv})
                 * $signed({{(DER_W+1){1'b0}}, i_gain_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_prod_p <= n_prod_p;
            r_prod_d <= n_prod_d;
            r_lost   <= i_lost;
        end
    end

    assign o_valid  = r_valid;
    assign o_prod_p = r_prod_p;
    assign o_prod_d = r_prod_d;
    assign o_lost   = r_lost;

endmodule

/* sv/dps_drive.sv */
// Stage three: correction sum, drive values, cap and floor, result register.
module dps_drive import dps_pkg::*; #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [SAMPLE_BITS+GAIN_W+1:0] i_prod_p,
    input  logic signed [SAMPLE_BITS+GAIN_W+2:0] i_prod_d,
    input  logic                                 i_lost,
    input  logic [SPEED_W-1:0]                   i_cruise,
    input  logic [SPEED_W-1:0]                   i_drive_cap,
    input  logic [SPEED_W-1:0]                   i_drive_floor,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [SPEED_W-1:0]                   o_left_drive,
    output logic [SPEED_W-1:0]                   o_right_drive,
    output logic                                 o_line_lost
);

    localparam int PP_W  = SAMPLE_BITS + GAIN_W + 2;
    localparam int PD_W  = SAMPLE_BITS + GAIN_W + 3;
    localparam int SUM_W = PD_W + 1;
    localparam int DRV_W = SUM_W + 1;

    function automatic logic [SPEED_W-1:0] clamp_drive(
        input logic signed [DRV_W-1:0] v,
        input logic [SPEED_W-1:0]      hi,
        input logic [SPEED_W-1:0]      lo
    );
        logic signed [DRV_W-1:0] hx;
        logic signed [DRV_W-1:0] lx;
        logic signed [DRV_W-1:0] t;
        hx = $signed({{(DRV_W-SPEED_W){1'b0}}, hi});
        lx = $signed({{(DRV_W-SPEED_W){1'b0}}, lo});
        t  = (v > hx) ? hx : v;
        // floor last so it wins over a crossed cap
        t  = (t < lx) ? lx : t;
        return t[SPEED_W-1:0];
    endfunction

    logic                    r_valid;
    logic signed [SUM_W-1:0] corr;
    logic signed [DRV_W-1:0] base_x;
    logic signed [DRV_W-1:0] corr_x;
    logic signed [DRV_W-1:0] left_v;
    logic signed [DRV_W-1:0] right_v;
    logic [SPEED_W-1:0]      r_left_drive;
    logic [SPEED_W-1:0]      r_right_drive;
    logic                    r_line_lost;
    logic                    load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        corr    = $signed({{2{i_prod_p[PP_W-1]}}, i_prod_p})
                + $signed({i_prod_d[PD_W-1], i_prod_d});
        base_x  = $signed({{(DRV_W-SPEED_W){1'b0}}, i_cruise});
        corr_x  = $signed({corr[SUM_W-1], corr});
        left_v  = base_x - corr_x;
        right_v = base_x + corr_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_left_drive  <= clamp_drive(left_v, i_drive_cap, i_drive_floor);
            r_right_drive <= clamp_drive(right_v, i_drive_cap, i_drive_floor);
            r_line_lost   <= i_lost;
        end
    end

    assign o_valid       = r_valid;
    assign o_left_drive  = r_left_drive;
    assign o_right_drive = r_right_drive;
    assign o_line_lost   = r_line_lost;

endmodule

/* sim/differential_pd_steering_core_checker.sv */
// Scoreboard for the steering core: mirrors its PD arithmetic and checks every drive result.
module differential_pd_steering_core_checker import dps_pkg::*; #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_left_sample,
    input  logic [SAMPLE_BITS-1:0] i_right_sample,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [SPEED_W-1:0]     i_left_drive,
    input  logic [SPEED_W-1:0]     i_right_drive,
    input  logic                   i_line_lost,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SPEED_W-1:0] left_drive;
        logic [SPEED_W-1:0] right_drive;
        logic               line_lost;
    } t_drive_result;

    t_cfg                        steer_cfg;
    logic signed [SAMPLE_BITS:0] steer_error;
    t_drive_result               expected_drives_q[$];
    int                          mismatches = 0;

    // Cap first, then floor: the floor wins when the limits cross.
    function automatic logic [SPEED_W-1:0] clamp_speed(input longint drive);
        longint v;
        v = drive;
        if (v > longint'(steer_cfg.drive_cap)) v = longint'(steer_cfg.drive_cap);
        if (v < longint'(steer_cfg.drive_floor)) v = longint'(steer_cfg.drive_floor);
        return v[SPEED_W-1:0];
    endfunction

    function automatic t_drive_result steer(input logic [SAMPLE_BITS-1:0] left,
                                            input logic [SAMPLE_BITS-1:0] right,
                                            input logic signed [SAMPLE_BITS:0] prev_err,
                                            output logic signed [SAMPLE_BITS:0] new_err);
        t_drive_result res;
        logic          lost;
        longint        err;
        longint        deriv;
        longint        corr;
        lost = (left < steer_cfg.lost_threshold) && (right < steer_cfg.lost_threshold);
        // hold the error when the line is lost, so the derivative drops out
        if (lost) err = longint'(prev_err);
        else      err = longint'(left) - longint'(right);
        deriv = err - longint'(prev_err);
        corr  = longint'(steer_cfg.gain_p) * err + longint'(steer_cfg.gain_d) * deriv;
        res.left_drive  = clamp_speed(longint'(steer_cfg.cruise) - corr);
        res.right_drive = clamp_speed(longint'(steer_cfg.cruise) + corr);
        res.line_lost   = lost;
        new_err = err[SAMPLE_BITS:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_drive_result               want;
        logic signed [SAMPLE_BITS:0] next_err;
        if (!i_rst_n) begin
            steer_cfg = '{gain_p: GAIN_P_RST, gain_d: GAIN_D_RST, cruise: BASE_RST,
                          drive_cap: MAX_RST, drive_floor: MIN_RST,
                          lost_threshold: THRESHOLD_RST};
            steer_error = '0;
            expected_drives_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_drives_q.size() == 0) begin
                    $error("drive result with nothing expected: left %0d right %0d lost %0b",
                           i_left_drive, i_right_drive, i_line_lost);
                    mismatches++;
                end else begin
                    want = expected_drives_q.pop_front();
                    if (i_left_drive !== want.left_drive) begin
                        $error("left_drive: expected %0d, got %0d",
                               want.left_drive, i_left_drive);
                        mismatches++;
                    end
                    if (i_right_drive !== want.right_drive) begin
                        $error("right_drive: expected %0d, got %0d",
                               want.right_drive, i_right_drive);
                        mismatches++;
                    end
                    if (i_line_lost !== want.line_lost) begin
                        $error("line_lost: expected %0b, got %0b",
                               want.line_lost, i_line_lost);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_drives_q.push_back(steer(i_left_sample, i_right_sample,
                                                  steer_error, next_err));
                steer_error = next_err;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_GAIN_P:         steer_cfg.gain_p         = i_cfg_wdata[GAIN_W-1:0];
                    CFG_GAIN_D:         steer_cfg.gain_d         = i_cfg_wdata[GAIN_W-1:0];
                    CFG_CRUISE:         steer_cfg.cruise         = i_cfg_wdata[SPEED_W-1:0];
                    CFG_DRIVE_CAP:      steer_cfg.drive_cap      = i_cfg_wdata[SPEED_W-1:0];
                    CFG_DRIVE_FLOOR:    steer_cfg.drive_floor    = i_cfg_wdata[SPEED_W-1:0];
                    CFG_LOST_THRESHOLD: steer_cfg.lost_threshold = i_cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_drives_q.size();
        o_fail_count <= mismatches;
    end

endmodule

/* sim/differential_pd_steering_core_test.sv */
// Top of the steering core testbench: clock, reset, stimulus, receiver stalls and verdict.
module differential_pd_steering_core_test;
    import dps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS     = 12;
    localparam int RESET_CYCLES    = 7;
    localparam int RANDOM_ITEMS    = 1800;
    // the pipeline is three deep; this extra settling margin covers any straggler
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int TIMEOUT_NS      = 2_000_000;

    // indexes the block has no register behind; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx      = '0;
    logic [CFG_W-1:0]       cfg_wdata    = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic [SAMPLE_BITS-1:0] left_sample  = '0;
    logic [SAMPLE_BITS-1:0] right_sample = '0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [SPEED_W-1:0]     left_drive;
    logic [SPEED_W-1:0]     right_drive;
    logic                   line_lost;

    int fail_count;
    int pending;
    // 0: both sides run flat out; 1: random gaps on both sides
    int idle_mode     = 1;
    // each bump asks the receiver for one long hold-off
    int pressure_reqs = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    differential_pd_steering_core #(
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_left_sample  (left_sample),
        .i_right_sample (right_sample),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_left_drive   (left_drive),
        .o_right_drive  (right_drive),
        .o_line_lost    (line_lost)
    );

    differential_pd_steering_core_checker #(
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) drive_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_left_sample  (left_sample),
        .i_right_sample (right_sample),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_left_drive   (left_drive),
        .i_right_drive  (right_drive),
        .i_line_lost    (line_lost),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (idle_mode == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, 40));
        endcase
    endfunction

    // One register write: enable high for exactly one edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Load a whole setting. Junk goes into the unused upper bits of the
    // 12-bit registers, and the two unmapped indexes get a write as well.
    task automatic apply_settings(input t_cfg c);
        write_reg(CFG_GAIN_P,         {4'($urandom), c.gain_p});
        write_reg(CFG_GAIN_D,         {4'($urandom), c.gain_d});
        write_reg(CFG_CRUISE,         c.cruise);
        write_reg(CFG_DRIVE_CAP,      c.drive_cap);
        write_reg(CFG_DRIVE_FLOOR,    c.drive_floor);
        write_reg(CFG_LOST_THRESHOLD, {4'($urandom), c.lost_threshold});
        write_reg(CFG_UNMAPPED_A,     CFG_W'($urandom));
        write_reg(CFG_UNMAPPED_B,     CFG_W'($urandom));
    endtask

    // Offer one sample pair and hold it until the block takes it. Returns at
    // the accepting edge with valid still high, so the next call can keep it
    // up for a back-to-back item.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] left,
                               input logic [SAMPLE_BITS-1:0] right);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        left_sample  <= left;
        right_sample <= right;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and wait until every result is back and the pipeline has
    // had time to empty; the block is then safe to reconfigure.
    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        t_cfg                   setting;
        logic [SAMPLE_BITS-1:0] left;
        logic [SAMPLE_BITS-1:0] right;
        int                     phase;
        int                     phase_len;
        int                     kind;
        int                     sent;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset setting: line lost from a zero error, full-scale
        // error both ways, a lost line holding a large error, and samples
        // right at the threshold edge.
        send_sample('0, '0);
        send_sample(SAMPLE_MAX, '0);
        send_sample(SAMPLE_BITS'(10), SAMPLE_BITS'(20));
        send_sample(SAMPLE_BITS'(99), SAMPLE_BITS'(99));
        send_sample(SAMPLE_BITS'(100), '0);
        send_sample('0, SAMPLE_BITS'(100));
        send_sample(SAMPLE_BITS'(99), SAMPLE_BITS'(100));
        send_sample('0, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_BITS'(60), SAMPLE_BITS'(50));
        settle_idle();

        // Directed, top values for gains, cruise value and cap with a zero floor, and a threshold
        // that flags a pair as lost when both samples are short of full scale.
        setting = '{gain_p: '1, gain_d: '1, cruise: '1, drive_cap: '1,
                    drive_floor: '0, lost_threshold: '1};
        apply_settings(setting);
        send_sample(SAMPLE_MAX, '0);
        send_sample('0, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX - 1), SAMPLE_BITS'(SAMPLE_MAX - 1));
        send_sample('0, '0);
        send_sample(SAMPLE_BITS'(1), '0);
        settle_idle();

        // Directed, crossed limits: floor above cap, so both drives sit at
        // the floor. A zero threshold never flags the line as lost.
        setting = '{gain_p: 12'd3, gain_d: 12'd2, cruise: 16'd30000,
                    drive_cap: 16'd1000, drive_floor: 16'd50000, lost_threshold: '0};
        apply_settings(setting);
        send_sample('0, '0);
        send_sample(SAMPLE_MAX, '0);
        send_sample(SAMPLE_BITS'(5), SAMPLE_BITS'(9));
        settle_idle();

        // Directed, zero cruise value and floor: a drive that underflows lands on zero.
        setting = '{gain_p: 12'd1, gain_d: 12'd1, cruise: '0,
                    drive_cap: '1, drive_floor: '0, lost_threshold: 12'd1};
        apply_settings(setting);
        send_sample('0, '0);
        send_sample(SAMPLE_MAX, '0);
        send_sample('0, SAMPLE_MAX);
        settle_idle();

        // Random phases: a fresh setting each, then a batch of samples.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            setting.gain_p = pick_gain();
            setting.gain_d = pick_gain();
            if ($urandom_range(0, 1)) begin
                // well-ordered limits with the cruise value inside them
                setting.drive_floor = SPEED_W'($urandom_range(0, 30000));
                setting.drive_cap   = SPEED_W'($urandom_range(setting.drive_floor, 16'hFFFF));
                setting.cruise      = SPEED_W'($urandom_range(setting.drive_floor,
                                                              setting.drive_cap));
            end else begin
                // anything goes, crossed limits included
                setting.drive_floor = SPEED_W'($urandom);
                setting.drive_cap   = SPEED_W'($urandom);
                setting.cruise      = SPEED_W'($urandom);
            end
            case ($urandom_range(0, 5))
                0:       setting.lost_threshold = '0;
                1:       setting.lost_threshold = '1;
                2:       setting.lost_threshold = THR_W'($urandom);
                default: setting.lost_threshold = THR_W'($urandom_range(0, 400));
            endcase
            apply_settings(setting);

            // First phase runs flat out with one long receiver hold-off so
            // the pipeline fills and backs up into the input; one later phase
            // repeats the hold-off, most often with random gaps around it.
            idle_mode = (phase == 0) ? 0 : (($urandom_range(0, 3) != 0) ? 1 : 0);
            if (phase == 0 || phase == 4) pressure_reqs <= pressure_reqs + 1;

            phase_len = $urandom_range(80, 220);
            repeat (phase_len) begin
                kind  = $urandom_range(0, 9);
                left  = SAMPLE_BITS'($urandom);
                right = SAMPLE_BITS'($urandom);
                if (kind < 2 && setting.lost_threshold != 0) begin
                    // both under the threshold: line lost
                    left  = SAMPLE_BITS'($urandom_range(0, setting.lost_threshold - 1));
                    right = SAMPLE_BITS'($urandom_range(0, setting.lost_threshold - 1));
                end else if (kind < 4) begin
                    // small steering error, where the clamp rarely bites
                    right = SAMPLE_BITS'(left + $urandom_range(0, 16) - 8);
                end else if (kind == 4) begin
                    left  = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
                    right = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
                end
                send_sample(left, right);
                sent++;
            end
            settle_idle();
            phase++;
        end

        if (fail_count == 0) begin
            $display("differential_pd_steering_core_test: PASS");
        end else begin
            $display("differential_pd_steering_core_test: FAIL");
        end
        $finish;
    end

    // Receiver: ready for a short run, then maybe a gap; serve any hold-off
    // request with a long stall counted here.
    initial begin : receiver
        int run;
        int gap;
        int served;
        served = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (pressure_reqs > served) begin
                served++;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_ready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        #TIMEOUT_NS;
        $display("differential_pd_steering_core_test: FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/dps_pkg.sv
sv/dps_error.sv
sv/dps_mult.sv
sv/dps_drive.sv
sv/differential_pd_steering_core.sv
sim/differential_pd_steering_core_checker.sv
sim/differential_pd_steering_core_test.sv
